>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros shared by the rtl, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define LPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define LPS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LPS_ASSERT(lbl, prop, msg)
`define LPS_NEVER(lbl, expr, msg)
`endif

`endif

>>> hdl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// shared constants and types of the lexicographic point sorter
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 32;
    localparam int DEF_POS_BITS   = $clog2(DEF_MAX_POINTS);
    localparam int SPECIES_BITS   = 4;
    localparam int ORIGIN_BITS    = 6;
    localparam int TAG_BITS       = SPECIES_BITS + ORIGIN_BITS;

    typedef enum logic [1:0] {
        STATE_LOAD,
        STATE_FLUSH,
        STATE_DRAIN
    } lps_state_t;

    // per-cycle command to every cell of the chain
    typedef struct packed {
        logic insert;   // compare and pass along
        logic shift;    // move held records one cell towards the output
    } cell_ctrl_t;

endpackage

>>> hdl/lps_cell.sv
// ----------------------------------------------------------------------------
// lps_cell
// one insertion cell: keeps the smaller record, hands the larger one on
// ----------------------------------------------------------------------------
module lps_cell
    import lps_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int POS_BITS   = DEF_POS_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cell_ctrl_t                       ctrl,
    input  logic                             in_valid,
    input  logic [3*COORD_BITS+POS_BITS-1:0] in_key,
    input  logic [TAG_BITS-1:0]              in_tag,
    input  logic                             right_valid,
    input  logic [3*COORD_BITS+POS_BITS-1:0] right_key,
    input  logic [TAG_BITS-1:0]              right_tag,
    output logic                             held_valid,
    output logic [3*COORD_BITS+POS_BITS-1:0] held_key,
    output logic [TAG_BITS-1:0]              held_tag,
    output logic                             pass_valid,
    output logic [3*COORD_BITS+POS_BITS-1:0] pass_key,
    output logic [TAG_BITS-1:0]              pass_tag
);

    localparam int KEY_W = 3 * COORD_BITS + POS_BITS;
    // flipping each sign bit gives an unsigned order over x, y, z, then position
    localparam logic [KEY_W-1:0] FLIP =
        {{3{1'b1, {(COORD_BITS-1){1'b0}}}}, {POS_BITS{1'b0}}};

    logic                held_valid_reg, held_valid_next;
    logic [KEY_W-1:0]    held_key_reg, held_key_next;
    logic [TAG_BITS-1:0] held_tag_reg, held_tag_next;
    logic                pass_valid_reg, pass_valid_next;
    logic [KEY_W-1:0]    pass_key_reg, pass_key_next;
    logic [TAG_BITS-1:0] pass_tag_reg, pass_tag_next;
    logic                held_after;

    // load position breaks ties, so identical records keep their load order
    assign held_after = (held_key_reg ^ FLIP) > (in_key ^ FLIP);

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_key_next   = held_key_reg;
        held_tag_next   = held_tag_reg;
        pass_valid_next = 1'b0;
        pass_key_next   = pass_key_reg;
        pass_tag_next   = pass_tag_reg;
        if (ctrl.shift)
        begin
            held_valid_next = right_valid;
            held_key_next   = right_key;
            held_tag_next   = right_tag;
        end
        else if (ctrl.insert && in_valid)
        begin
            if (!held_valid_reg)
            begin
                held_valid_next = 1'b1;
                held_key_next   = in_key;
                held_tag_next   = in_tag;
            end
            else if (held_after)
            begin
                held_key_next   = in_key;
                held_tag_next   = in_tag;
                pass_valid_next = 1'b1;
                pass_key_next   = held_key_reg;
                pass_tag_next   = held_tag_reg;
            end
            else
            begin
                pass_valid_next = 1'b1;
                pass_key_next   = in_key;
                pass_tag_next   = in_tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_key_reg <= held_key_next;
        held_tag_reg <= held_tag_next;
        pass_key_reg <= pass_key_next;
        pass_tag_reg <= pass_tag_next;
    end

    assign held_valid = held_valid_reg;
    assign held_key   = held_key_reg;
    assign held_tag   = held_tag_reg;
    assign pass_valid = pass_valid_reg;
    assign pass_key   = pass_key_reg;
    assign pass_tag   = pass_tag_reg;

endmodule

>>> hdl/lexicographic_point_sorter.sv
// ----------------------------------------------------------------------------
// lexicographic_point_sorter
// systolic insertion sorter for atom records, ascending by x, then y, then z
// ----------------------------------------------------------------------------
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  input   | in_valid/in_ready, coord_x/y/z, species,   | into block
//          | last_in                                    |
//  output  | out_valid/out_ready, sorted_x/y/z,         | out of block
//          | sorted_species, origin_pos, last_out       |
//
//  load: one record per cycle, in_ready stays high until the last_in transfer
//  settle: after last_in, the flush state gives a record the time it needs to
//          walk the full length of the cell chain
//  drain: one sorted result per cycle while out_ready is high, taken straight from the first cell
//  in_ready is low from the last_in transfer until the final result is taken
//  a stalled output simply freezes the chain; reset empties every cell
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lexicographic_point_sorter
    import lps_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic [SPECIES_BITS-1:0]      species,
    input  logic                         last_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] sorted_x,
    output logic signed [COORD_BITS-1:0] sorted_y,
    output logic signed [COORD_BITS-1:0] sorted_z,
    output logic [SPECIES_BITS-1:0]      sorted_species,
    output logic [ORIGIN_BITS-1:0]       origin_pos,
    output logic                         last_out
);

    localparam int POS_W = $clog2(MAX_POINTS);
    localparam int KEY_W = 3 * COORD_BITS + POS_W;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int FL_W  = $clog2(MAX_POINTS);

    lps_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  load_count_reg, load_count_next;
    logic [FL_W-1:0]   flush_cnt_reg, flush_cnt_next;

    cell_ctrl_t        ctrl;
    logic              in_xfer;
    logic              out_xfer;
    logic              full;
    logic              ins_valid;
    logic [KEY_W-1:0]  ins_key;
    logic [TAG_BITS-1:0] ins_tag;

    // chain wiring, one entry per cell
    logic [MAX_POINTS-1:0] held_valid;
    logic [KEY_W-1:0]      held_key [MAX_POINTS];
    logic [TAG_BITS-1:0]   held_tag [MAX_POINTS];
    logic [MAX_POINTS-1:0] pass_valid;
    logic [KEY_W-1:0]      pass_key [MAX_POINTS];
    logic [TAG_BITS-1:0]   pass_tag [MAX_POINTS];

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;
    assign full     = (load_count_reg == CNT_W'(MAX_POINTS));

    // a record that finds the chain full is dropped, its last_in still counts
    assign ins_valid = in_xfer && !full;
    // full load position sits below z as the final tie-break
    assign ins_key   = {coord_x, coord_y, coord_z, POS_W'(load_count_reg)};
    assign ins_tag   = {species, ORIGIN_BITS'(load_count_reg)};

    // control sequencer
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        flush_cnt_next  = flush_cnt_reg;
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        case (state_reg)
            STATE_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!full)
                    begin
                        load_count_next = load_count_reg + 1'b1;
                    end
                    if (last_in)
                    begin
                        state_next     = STATE_FLUSH;
                        flush_cnt_next = '0;
                    end
                end
            end
            STATE_FLUSH:
            begin
                // let records still in the pass registers reach their place
                flush_cnt_next = flush_cnt_reg + 1'b1;
                if (flush_cnt_reg == FL_W'(MAX_POINTS - 1))
                begin
                    state_next = STATE_DRAIN;
                end
            end
            STATE_DRAIN:
            begin
                out_valid = held_valid[0];
                if (out_valid && out_ready && last_out)
                begin
                    state_next      = STATE_LOAD;
                    load_count_next = '0;
                end
            end
            default:
            begin
                state_next = STATE_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= STATE_LOAD;
            load_count_reg <= '0;
            flush_cnt_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            flush_cnt_reg  <= flush_cnt_next;
        end
    end

    // cells compare and pass while loading or settling, shift on each taken result while draining
    assign ctrl.insert = (state_reg != STATE_DRAIN);
    assign ctrl.shift  = (state_reg == STATE_DRAIN) && out_xfer;

    // the chain: cell 0 takes new records and presents the smallest
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        logic                in_v;
        logic [KEY_W-1:0]    in_k;
        logic [TAG_BITS-1:0] in_t;
        logic                rt_v;
        logic [KEY_W-1:0]    rt_k;
        logic [TAG_BITS-1:0] rt_t;

        if (i == 0)
        begin : g_head
            assign in_v = ins_valid;
            assign in_k = ins_key;
            assign in_t = ins_tag;
        end
        else
        begin : g_link
            assign in_v = pass_valid[i-1];
            assign in_k = pass_key[i-1];
            assign in_t = pass_tag[i-1];
        end

        if (i == MAX_POINTS - 1)
        begin : g_tail
            assign rt_v = 1'b0;
            assign rt_k = '0;
            assign rt_t = '0;
        end
        else
        begin : g_next
            assign rt_v = held_valid[i+1];
            assign rt_k = held_key[i+1];
            assign rt_t = held_tag[i+1];
        end

        lps_cell #(
            .COORD_BITS (COORD_BITS),
            .POS_BITS   (POS_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .in_valid    (in_v),
            .in_key      (in_k),
            .in_tag      (in_t),
            .right_valid (rt_v),
            .right_key   (rt_k),
            .right_tag   (rt_t),
            .held_valid  (held_valid[i]),
            .held_key    (held_key[i]),
            .held_tag    (held_tag[i]),
            .pass_valid  (pass_valid[i]),
            .pass_key    (pass_key[i]),
            .pass_tag    (pass_tag[i])
        );
    end

    // results come straight from the first cell's registers
    assign sorted_x       = held_key[0][KEY_W-1 -: COORD_BITS];
    assign sorted_y       = held_key[0][KEY_W-COORD_BITS-1 -: COORD_BITS];
    assign sorted_z       = held_key[0][POS_W+COORD_BITS-1 -: COORD_BITS];
    assign sorted_species = held_tag[0][TAG_BITS-1 -: SPECIES_BITS];
    assign origin_pos     = held_tag[0][ORIGIN_BITS-1:0];
    // final result when nothing waits behind the first cell
    assign last_out       = !held_valid[1];

    // the two channels are never open together
    `LPS_NEVER(a_no_overlap, in_ready && out_valid, "input and output open together")
    // the final transfer returns the block to loading
    `LPS_ASSERT(a_back_to_load, out_valid && out_ready && last_out |=> in_ready, "no reload")
    // held records form an unbroken run from the first cell while draining
    `LPS_ASSERT(a_packed_chain,
        state_reg == STATE_DRAIN |-> ((held_valid + 1'b1) & held_valid) == '0,
        "gap in the cell chain")
    // the load count never passes the chain length
    `LPS_ASSERT(a_count_bound, load_count_reg <= CNT_W'(MAX_POINTS), "load count overrun")

endmodule
